/* sv/rdq_pkg.sv */
package rdq_pkg;

	localparam int Depth  = 64;
	localparam int DataW  = 32;
	localparam int AddrW  = $clog2(Depth);
	localparam int CntW   = $clog2(Depth + 1);
	localparam int PosW   = 7;
	localparam int ElemW  = 32;
	localparam int StatW  = 2;
	localparam int ReqW   = 3;
	localparam int CmpW   = (PosW > CntW) ? PosW : CntW;
	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [ReqW-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_REMOVE     = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [StatW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_PUSH_F,
		ACT_PUSH_B,
		ACT_POP_F,
		ACT_POP_B,
		ACT_INS,
		ACT_REM,
		ACT_READ,
		ACT_CLEAR
	} act_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SHIFT_RD,
		BK_SHIFT_WR,
		BK_FINAL_WR,
		BK_READ_WAIT
	} bk_state_t;

	typedef struct packed {
		op_t             op;
		logic [PosW-1:0] pos;
		logic [DataW-1:0] data;
	} rdq_item_t;

	function automatic logic [AddrW-1:0] slot_inc(input logic [AddrW-1:0] a);
		return (a == AddrW'(Depth - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [AddrW-1:0] slot_dec(input logic [AddrW-1:0] a);
		return (a == '0) ? AddrW'(Depth - 1) : a - 1'b1;
	endfunction

	function automatic logic [AddrW-1:0] slot_add(input logic [AddrW-1:0] h,
	                                             input logic [CntW-1:0] l);
		logic [CntW:0] s;
		s = (CntW+1)'(h) + (CntW+1)'(l);
		if (s >= (CntW+1)'(Depth)) s = s - (CntW+1)'(Depth);
		return s[AddrW-1:0];
	endfunction

endpackage

/* sv/rdq_front.sv */
module rdq_front import rdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [ReqW-1:0]   req_type,
	input  logic [PosW-1:0]   position,
	input  logic [ElemW-1:0]  element_data,
	input  logic              q_full,
	output logic              q_push,
	output rdq_item_t         q_item
);

	logic      valid_s1;
	rdq_item_t item_s1;
	logic      load;

	assign req_stall = valid_s1 && q_full;
	assign load      = req_valid && !req_stall;
	assign q_push    = valid_s1 && !q_full;
	assign q_item    = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.op   <= op_t'(req_type);
			item_s1.pos  <= position;
			item_s1.data <= element_data[DataW-1:0];
		end
	end

endmodule

/* sv/rdq_queue.sv */
module rdq_queue import rdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rdq_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output rdq_item_t pop_item
);

	rdq_item_t              entry_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [QCntW-1:0]       fill_q;

	function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = fill_q == QCntW'(QDepth);
	assign pop_valid = fill_q != '0;
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

/* sv/rdq_back.sv */
module rdq_back import rdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rdq_item_t         q_item,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [StatW-1:0]  status,
	output logic [ElemW-1:0]  read_data,
	output logic [PosW-1:0]   occupancy
);

	bk_state_t         state_q, state_d;
	logic [AddrW-1:0]  head_q, head_d;
	logic [CntW-1:0]   count_q, count_d;
	logic [AddrW-1:0]  src_q, dst_q;
	logic [CntW-1:0]   left_q;
	logic              dir_up_q, fin_wr_q;
	logic [DataW-1:0]  v_q;

	logic [DataW-1:0]  mem [Depth];
	logic [DataW-1:0]  rdata_q;
	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr, mem_raddr;
	logic [DataW-1:0]  mem_wdata;

	logic              rsp_valid_q;
	stat_t             rsp_stat_q;
	logic [DataW-1:0]  rsp_rd_q;
	logic [CntW-1:0]   rsp_occ_q;

	logic              out_free, out_load;
	stat_t             out_stat;
	logic [DataW-1:0]  out_rd;
	logic [CntW-1:0]   out_occ;

	act_t              act;
	stat_t             stat_c;
	logic [CmpW-1:0]   posx, cntx;
	logic              full_c, empty_c, pos_zero, ps_below;
	logic [AddrW-1:0]  ps, tail, hd_inc, hd_dec;
	logic              setup_up;
	logic [AddrW-1:0]  setup_src, setup_dst;
	logic [CntW-1:0]   setup_n;

	assign posx     = CmpW'(q_item.pos);
	assign cntx     = CmpW'(count_q);
	assign full_c   = count_q == CntW'(Depth);
	assign empty_c  = count_q == '0;
	assign pos_zero = q_item.pos == '0;
	assign ps       = slot_add(head_q, CntW'(q_item.pos));
	assign tail     = slot_add(head_q, count_q);
	assign ps_below = ps < tail;
	assign hd_inc   = slot_inc(head_q);
	assign hd_dec   = slot_dec(head_q);

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign q_pop    = (state_q == BK_IDLE) && q_valid && out_free;

	// classify against current head and count
	always_comb begin
		act    = ACT_NONE;
		stat_c = ST_OK;
		case (q_item.op)
			OP_PUSH_FRONT: begin
				if (full_c) stat_c = ST_FULL;
				else        act = ACT_PUSH_F;
			end
			OP_PUSH_BACK: begin
				if (full_c) stat_c = ST_FULL;
				else        act = ACT_PUSH_B;
			end
			OP_POP_FRONT: begin
				if (empty_c) stat_c = ST_EMPTY;
				else         act = ACT_POP_F;
			end
			OP_POP_BACK: begin
				if (empty_c) stat_c = ST_EMPTY;
				else         act = ACT_POP_B;
			end
			OP_INSERT: begin
				if (posx > cntx)       stat_c = ST_RANGE;
				else if (full_c)       stat_c = ST_FULL;
				else if (posx == cntx) act = ACT_PUSH_B;
				else if (pos_zero)     act = ACT_PUSH_F;
				else                   act = ACT_INS;
			end
			OP_REMOVE: begin
				if (posx >= cntx)               stat_c = ST_RANGE;
				else if (posx == cntx - 1'b1)   act = ACT_POP_B;
				else if (pos_zero)              act = ACT_POP_F;
				else                            act = ACT_REM;
			end
			OP_READ: begin
				if (posx >= cntx) stat_c = ST_RANGE;
				else              act = ACT_READ;
			end
			OP_CLEAR: begin
				act = ACT_CLEAR;
			end
			default: begin
				act = ACT_NONE;
			end
		endcase
	end

	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		setup_up  = 1'b0;
		setup_src = head_q;
		setup_dst = head_q;
		setup_n   = '0;
		case (act)
			ACT_PUSH_F: begin
				count_d = count_q + 1'b1;
				if (!empty_c) head_d = hd_dec;
			end
			ACT_PUSH_B: begin
				count_d = count_q + 1'b1;
			end
			ACT_POP_F: begin
				count_d = count_q - 1'b1;
				if (count_q != CntW'(1)) head_d = hd_inc;
			end
			ACT_POP_B: begin
				count_d = count_q - 1'b1;
			end
			ACT_CLEAR: begin
				count_d = '0;
			end
			ACT_INS: begin
				count_d = count_q + 1'b1;
				if (ps_below) begin
					setup_up  = 1'b0;
					setup_dst = tail;
					setup_src = slot_dec(tail);
					setup_n   = CntW'(cntx - posx);
				end else begin
					head_d    = hd_dec;
					setup_up  = 1'b1;
					setup_dst = hd_dec;
					setup_src = head_q;
					setup_n   = CntW'(posx);
				end
			end
			ACT_REM: begin
				count_d = count_q - 1'b1;
				if (ps_below) begin
					setup_up  = 1'b1;
					setup_dst = ps;
					setup_src = slot_inc(ps);
					setup_n   = CntW'(cntx - posx - 1'b1);
				end else begin
					head_d    = hd_inc;
					setup_up  = 1'b0;
					setup_dst = ps;
					setup_src = slot_dec(ps);
					setup_n   = CntW'(posx);
				end
			end
			default: begin
				head_d = head_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					if (act == ACT_INS || act == ACT_REM) state_d = BK_SHIFT_RD;
					else if (act == ACT_READ)             state_d = BK_READ_WAIT;
				end
			end
			BK_SHIFT_RD: begin
				state_d = BK_SHIFT_WR;
			end
			BK_SHIFT_WR: begin
				if (left_q == CntW'(1)) state_d = fin_wr_q ? BK_FINAL_WR : BK_IDLE;
				else                    state_d = BK_SHIFT_RD;
			end
			BK_FINAL_WR: begin
				state_d = BK_IDLE;
			end
			BK_READ_WAIT: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// memory and result control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst_q;
		mem_wdata = rdata_q;
		mem_raddr = src_q;
		out_load  = 1'b0;
		out_stat  = ST_OK;
		out_rd    = '0;
		out_occ   = count_q;
		case (state_q)
			BK_IDLE: begin
				out_stat = stat_c;
				out_occ  = count_d;
				if (q_pop) begin
					out_load = !(act == ACT_INS || act == ACT_REM || act == ACT_READ);
					if (act == ACT_PUSH_F) begin
						mem_we    = 1'b1;
						mem_waddr = empty_c ? head_q : hd_dec;
						mem_wdata = q_item.data;
					end else if (act == ACT_PUSH_B) begin
						mem_we    = 1'b1;
						mem_waddr = tail;
						mem_wdata = q_item.data;
					end else if (act == ACT_READ) begin
						mem_raddr = ps;
					end
				end
			end
			BK_SHIFT_RD: begin
				mem_raddr = src_q;
			end
			BK_SHIFT_WR: begin
				mem_we   = 1'b1;
				out_load = (left_q == CntW'(1)) && !fin_wr_q;
			end
			BK_FINAL_WR: begin
				mem_we    = 1'b1;
				mem_wdata = v_q;
				out_load  = 1'b1;
			end
			BK_READ_WAIT: begin
				out_load = 1'b1;
				out_rd   = rdata_q;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			left_q      <= '0;
			fin_wr_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				head_q   <= head_d;
				count_q  <= count_d;
				left_q   <= setup_n;
				fin_wr_q <= act == ACT_INS;
			end else if (state_q == BK_SHIFT_WR) begin
				left_q <= left_q - 1'b1;
			end
			if (out_load)       rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			src_q    <= setup_src;
			dst_q    <= setup_dst;
			dir_up_q <= setup_up;
			v_q      <= q_item.data;
		end else if (state_q == BK_SHIFT_WR) begin
			dst_q <= src_q;
			src_q <= dir_up_q ? slot_inc(src_q) : slot_dec(src_q);
		end
		if (out_load) begin
			rsp_stat_q <= out_stat;
			rsp_rd_q   <= out_rd;
			rsp_occ_q  <= out_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_stat_q;
	assign read_data = ElemW'(rsp_rd_q);
	assign occupancy = PosW'(rsp_occ_q);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("element count beyond capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result word overwritten while stalled");

	a_shift_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SHIFT_WR) |-> (left_q != '0))
		else $error("shift step with no moves left");

	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SHIFT_RD) |=> (state_q == BK_SHIFT_WR))
		else $error("shift read not followed by write");
`endif

endmodule

/* sv/ring_deque_with_indexed_insert_core.sv */
// channel  dir  handshake             payload
// req      in   req_valid/req_stall   req_type, position, element_data
// rsp      out  rsp_valid/rsp_stall   status, read_data, occupancy
//
// a word passes a front register and a two-word queue before execution
// push, pop, clear and any error: result set in idle, read: via a ram wait state
// mid insert: shifts + final write, mid remove: shifts only, n elements moved
// (up to count-1), one read and one write per element on the single ram
// reset clears head, count and handshake state; ram contents stay unknown
// stall on rsp holds the result register; the queue keeps taking words until full
module ring_deque_with_indexed_insert_core import rdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [ReqW-1:0]   req_type,
	input  logic [PosW-1:0]   position,
	input  logic [ElemW-1:0]  element_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [StatW-1:0]  status,
	output logic [ElemW-1:0]  read_data,
	output logic [PosW-1:0]   occupancy
);

	logic      q_full, q_push, q_pop, q_valid;
	rdq_item_t front_item, back_item;

	rdq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.position     (position),
		.element_data (element_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (front_item)
	);

	rdq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (back_item)
	);

	rdq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (back_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.read_data (read_data),
		.occupancy (occupancy)
	);

endmodule
